@@ hw/rtl/rmkq_pkg.sv @@
package rmkq_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MEAS_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR        = 8'd3;

  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST      = 24'd32768;
  localparam logic [CFG_W-1:0] INITIAL_COVARIANCE_RST = 24'd655360;
  localparam logic [CFG_W-1:0] INITIAL_MEAS_NOISE_RST = 24'd262144;
  localparam logic [CFG_W-1:0] NOISE_FLOOR_RST        = 24'd131072;

  localparam int WIN_LEN   = 5;
  localparam int DIV_VW    = 34;  // widest divisor: predicted covariance plus noise
  localparam int K_DIV_N   = 49;  // gain dividend: 33-bit covariance scaled by 2^16
  localparam int STAB_N    = 33;  // 2^32
  localparam int SR_N      = 32;
  localparam int QUAL_N    = 20;
  localparam int MUL_STEPS = 17;  // gain and one-minus-gain are 17 bits wide
  localparam int SQRT_STEPS = 24; // root of a 48-bit radicand

  typedef logic signed [7:0] sample_t;
  typedef sample_t window_t [WIN_LEN];

  typedef enum logic [4:0] {
    S_IDLE,
    S_MED,
    S_VSUM,
    S_VMUL,
    S_VDIV,
    S_PRED,
    S_KDIV,
    S_KMUL,
    S_EUPD,
    S_PMUL,
    S_PUPD,
    S_HIST,
    S_SQRT,
    S_STAB,
    S_SRDIV,
    S_QDIV,
    S_OUT
  } state_t;

  // Median of five: the entry whose rank, with ties broken by position, is two.
  function automatic sample_t median5(input window_t w);
    logic [2:0] rank;
    sample_t m;
    m = w[0];
    for (int i = 0; i < WIN_LEN; i++) begin
      rank = '0;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (j != i) begin
          if ((w[j] < w[i]) || ((w[j] == w[i]) && (j < i))) begin
            rank = rank + 3'd1;
          end
        end
      end
      if (rank == 3'd2) begin
        m = w[i];
      end
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/rssi_median_kalman_quality.sv @@
// RSSI smoother: a five-sample median prefilter feeding an adaptive scalar
// Kalman filter, with a quality figure built from history spread and level.
//
// Input channel (in_valid/in_ready/in_rssi_sample) takes one signed dBm
// sample per beat. Output channel (out_valid/out_ready) returns one result
// beat per input: filtered_rssi in Q8.8, signal_quality in Q0.16 and
// median_applied. The configuration channel (cfg_valid/cfg_ready, index and
// 24-bit data) is always ready and should only be written while idle.
//
// One sample is processed at a time. Once the history holds more than five
// samples, the time goes to six bit-serial divisions at one quotient bit per
// cycle, two 17-step serial multiplies, a 24-step square root and two walks
// over the history memory; start-up samples skip some of these steps.
//
// The result sits in an output register; if the receiver stalls, the next
// sample is still accepted and processed, and the block waits at its last
// step until the register frees. Reset clears the filter, the window and
// the history count and restores the register defaults.
module rssi_median_kalman_quality #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [7:0]                     in_rssi_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [15:0]                    out_filtered_rssi,
  output logic [15:0]                           out_signal_quality,
  output logic                                  out_median_applied,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rmkq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmkq_pkg::CFG_W-1:0]            cfg_data
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = 8 + CNT_W;
  localparam int SQ_W   = 14 + CNT_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int VDIV_N = NUM_W + 16;
  localparam int DW     = (VDIV_N > rmkq_pkg::K_DIV_N) ? VDIV_N : rmkq_pkg::K_DIV_N;
  localparam int VW     = rmkq_pkg::DIV_VW;
  localparam int CW     = $clog2(DW + 1);

  // Configuration registers.
  logic [rmkq_pkg::CFG_W-1:0] pnoise_r, icov_r, inoise_r, floor_r;

  // Filter state.
  rmkq_pkg::state_t  state_r, state_nxt;
  rmkq_pkg::window_t window_r;
  logic [2:0]        wcnt_r;
  logic [CNT_W-1:0]  hcnt_r;
  logic [AW-1:0]     wr_r;
  logic              started_r;
  logic signed [31:0] est_r;
  logic [31:0]       cov_r;
  logic [31:0]       rn_r;
  logic              issued_r;
  logic              out_valid_r;

  // Per-sample working registers.
  rmkq_pkg::sample_t x_r, meas_r;
  logic              full_r;
  logic              post_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;
  logic signed [7:0] hist_q_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [NUM_W-1:0]  na_r, nb_r;
  logic [2*CNT_W-1:0] nn_r;
  logic [32:0]       pc_r;
  logic [16:0]       k_r;
  logic signed [33:0] diff_r;
  logic signed [50:0] mc_r, acc_r;
  logic [16:0]       mp_r;
  logic [4:0]        step_r;
  logic [47:0]       sv_r;
  logic [25:0]       srem_r;
  logic [23:0]       sroot_r;
  logic [16:0]       stab_r, sr_r;
  logic [15:0]       qual_r;
  logic [15:0]       q88_r;
  logic signed [15:0] out_rssi_r;
  logic [15:0]       out_qual_r;
  logic              out_med_r;

  logic [7:0] hist_mem [HISTORY_DEPTH];

  // Divider hookup.
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_q;
  logic [VW-1:0] div_b;
  logic [CW-1:0] div_n;

  rmkq_div #(
    .DW (DW),
    .VW (VW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .iters    (div_n),
    .done     (div_done),
    .quotient (div_q)
  );

  // Combinational helpers.
  logic              med_full;
  rmkq_pkg::sample_t med_meas;
  logic [CNT_W-1:0]  hcnt_inc;
  logic              walk_issue;
  logic signed [15:0] hsq;
  logic [SUM_W-1:0]  sum_abs;
  logic [2*SUM_W-1:0] sum_sqp;
  logic [NUM_W-1:0]  num_v;
  logic [33:0]       den;
  logic [16:0]       k_val;
  logic              acc_neg;
  logic [50:0]       acc_mag, acc_rnd;
  logic [31:0]       rnd32;
  logic [34:0]       pn_v;
  logic [32:0]       em, er;
  logic [15:0]       q88_v;
  logic signed [32:0] srs;
  logic [31:0]       sr_pos;
  logic [19:0]       qsum;
  logic [27:0]       sq_trial, sq_t;
  logic              sq_ge;
  logic [31:0]       var_v;

  assign med_full   = (wcnt_r == 3'(rmkq_pkg::WIN_LEN));
  assign med_meas   = med_full ? rmkq_pkg::median5(window_r) : x_r;
  assign hcnt_inc   = (hcnt_r == CNT_W'(HISTORY_DEPTH)) ? hcnt_r : hcnt_r + CNT_W'(1);
  assign walk_issue = idx_r < hcnt_r;
  assign hsq        = hist_q_r * hist_q_r;
  assign sum_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign sum_sqp    = {{SUM_W{1'b0}}, sum_abs} * {{SUM_W{1'b0}}, sum_abs};
  assign num_v      = na_r - nb_r;
  assign den        = {1'b0, pc_r} + {2'b0, rn_r};
  assign k_val      = (den == '0) ? '0 : div_q[16:0];
  assign var_v      = div_q[31:0];

  // Half-away-from-zero rounding of the gain product to Q16.16.
  assign acc_neg = acc_r[50];
  assign acc_mag = acc_neg ? (51'd0 - acc_r) : acc_r;
  assign acc_rnd = acc_mag + 51'd32768;
  assign rnd32   = acc_rnd[47:16];
  assign pn_v    = acc_r[50:16];

  // Estimate to Q8.8 with the same rounding, then saturation.
  assign em = est_r[31] ? (33'd0 - {est_r[31], est_r}) : {1'b0, est_r};
  assign er = (em + 33'd128) >> 8;
  always_comb begin
    if (!est_r[31]) begin
      q88_v = (er > 33'd32767) ? 16'h7FFF : er[15:0];
    end else begin
      q88_v = (er > 33'd32768) ? 16'h8000 : (16'd0 - er[15:0]);
    end
  end

  assign srs    = 33'(est_r) + 33'sd6553600;
  assign sr_pos = srs[32] ? 32'd0 : srs[31:0];
  assign qsum   = 20'({stab_r, 2'b00}) + 20'({stab_r, 1'b0}) + 20'({sr_r, 2'b00}) + 20'd5;

  assign sq_trial = {srem_r, sv_r[47:46]};
  assign sq_t     = {2'b00, sroot_r, 2'b01};
  assign sq_ge    = sq_trial >= sq_t;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmkq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    div_n     = '0;
    case (state_r)
      rmkq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = rmkq_pkg::S_MED;
        end
      end
      rmkq_pkg::S_MED: begin
        if (!started_r) begin
          state_nxt = rmkq_pkg::S_HIST;
        end else if (hcnt_r > CNT_W'(5)) begin
          state_nxt = rmkq_pkg::S_VSUM;
        end else begin
          state_nxt = rmkq_pkg::S_PRED;
        end
      end
      rmkq_pkg::S_VSUM: begin
        if (!walk_issue && !rd_vld_r) begin
          state_nxt = rmkq_pkg::S_VMUL;
        end
      end
      rmkq_pkg::S_VMUL: state_nxt = rmkq_pkg::S_VDIV;
      rmkq_pkg::S_VDIV: begin
        div_start = !issued_r;
        div_a     = DW'({num_v, 16'b0}) << (DW - VDIV_N);
        div_b     = VW'(nn_r);
        div_n     = CW'(VDIV_N);
        if (div_done) begin
          state_nxt = post_r ? rmkq_pkg::S_SQRT : rmkq_pkg::S_PRED;
        end
      end
      rmkq_pkg::S_PRED: state_nxt = rmkq_pkg::S_KDIV;
      rmkq_pkg::S_KDIV: begin
        div_start = !issued_r;
        div_a     = DW'({pc_r, 16'b0}) << (DW - rmkq_pkg::K_DIV_N);
        div_b     = VW'(den);
        div_n     = CW'(rmkq_pkg::K_DIV_N);
        if (div_done) begin
          state_nxt = rmkq_pkg::S_KMUL;
        end
      end
      rmkq_pkg::S_KMUL: begin
        if (step_r == 5'(rmkq_pkg::MUL_STEPS - 1)) begin
          state_nxt = rmkq_pkg::S_EUPD;
        end
      end
      rmkq_pkg::S_EUPD: state_nxt = rmkq_pkg::S_PMUL;
      rmkq_pkg::S_PMUL: begin
        if (step_r == 5'(rmkq_pkg::MUL_STEPS - 1)) begin
          state_nxt = rmkq_pkg::S_PUPD;
        end
      end
      rmkq_pkg::S_PUPD: state_nxt = rmkq_pkg::S_HIST;
      rmkq_pkg::S_HIST: begin
        state_nxt = (hcnt_inc < CNT_W'(3)) ? rmkq_pkg::S_OUT : rmkq_pkg::S_VSUM;
      end
      rmkq_pkg::S_SQRT: begin
        if (step_r == 5'(rmkq_pkg::SQRT_STEPS - 1)) begin
          state_nxt = rmkq_pkg::S_STAB;
        end
      end
      rmkq_pkg::S_STAB: begin
        div_start = !issued_r;
        div_a     = DW'({1'b1, 32'b0}) << (DW - rmkq_pkg::STAB_N);
        div_b     = VW'(25'(sroot_r) + 25'd65536);
        div_n     = CW'(rmkq_pkg::STAB_N);
        if (div_done) begin
          state_nxt = rmkq_pkg::S_SRDIV;
        end
      end
      rmkq_pkg::S_SRDIV: begin
        div_start = !issued_r;
        div_a     = DW'(sr_pos) << (DW - rmkq_pkg::SR_N);
        div_b     = VW'(7'd100);
        div_n     = CW'(rmkq_pkg::SR_N);
        if (div_done) begin
          state_nxt = rmkq_pkg::S_QDIV;
        end
      end
      rmkq_pkg::S_QDIV: begin
        div_start = !issued_r;
        div_a     = DW'(qsum) << (DW - rmkq_pkg::QUAL_N);
        div_b     = VW'(4'd10);
        div_n     = CW'(rmkq_pkg::QUAL_N);
        if (div_done) begin
          state_nxt = rmkq_pkg::S_OUT;
        end
      end
      rmkq_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rmkq_pkg::S_IDLE;
        end
      end
      default: state_nxt = rmkq_pkg::S_IDLE;
    endcase
  end

  // Configuration, filter state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnoise_r    <= rmkq_pkg::PROCESS_NOISE_RST;
      icov_r      <= rmkq_pkg::INITIAL_COVARIANCE_RST;
      inoise_r    <= rmkq_pkg::INITIAL_MEAS_NOISE_RST;
      floor_r     <= rmkq_pkg::NOISE_FLOOR_RST;
      for (int i = 0; i < rmkq_pkg::WIN_LEN; i++) begin
        window_r[i] <= '0;
      end
      wcnt_r      <= '0;
      hcnt_r      <= '0;
      wr_r        <= '0;
      started_r   <= 1'b0;
      est_r       <= '0;
      cov_r       <= '0;
      rn_r        <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rmkq_pkg::REG_PROCESS_NOISE:      pnoise_r <= cfg_data;
          rmkq_pkg::REG_INITIAL_COVARIANCE: icov_r   <= cfg_data;
          rmkq_pkg::REG_INITIAL_MEAS_NOISE: inoise_r <= cfg_data;
          rmkq_pkg::REG_NOISE_FLOOR:        floor_r  <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == rmkq_pkg::S_IDLE && in_valid) begin
        for (int i = 0; i < rmkq_pkg::WIN_LEN - 1; i++) begin
          window_r[i] <= window_r[i+1];
        end
        window_r[rmkq_pkg::WIN_LEN-1] <= in_rssi_sample;
        if (wcnt_r != 3'(rmkq_pkg::WIN_LEN)) begin
          wcnt_r <= wcnt_r + 3'd1;
        end
      end

      if (div_start) begin
        issued_r <= 1'b1;
      end else if (div_done) begin
        issued_r <= 1'b0;
      end

      // The first sample seeds the filter directly.
      if (state_r == rmkq_pkg::S_MED && !started_r) begin
        est_r     <= {{8{x_r[7]}}, x_r, 16'b0};
        cov_r     <= 32'(icov_r);
        rn_r      <= 32'(inoise_r);
        started_r <= 1'b1;
      end

      // Measurement noise follows the history variance, floored.
      if (state_r == rmkq_pkg::S_VDIV && div_done && !post_r) begin
        rn_r <= (var_v > 32'(floor_r)) ? var_v : 32'(floor_r);
      end

      if (state_r == rmkq_pkg::S_EUPD) begin
        est_r <= est_r + (acc_neg ? (32'd0 - rnd32) : rnd32);
      end

      if (state_r == rmkq_pkg::S_PUPD) begin
        cov_r <= (pn_v[34:32] != 3'd0) ? 32'hFFFF_FFFF : pn_v[31:0];
      end

      if (state_r == rmkq_pkg::S_HIST) begin
        hcnt_r <= hcnt_inc;
        wr_r   <= (wr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end

      if (state_r == rmkq_pkg::S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // History memory: one write per sample, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == rmkq_pkg::S_HIST) begin
      hist_mem[wr_r] <= x_r;
    end
    hist_q_r <= hist_mem[idx_r[AW-1:0]];
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    if (state_nxt != state_r) begin
      step_r <= '0;
    end else begin
      step_r <= step_r + 5'd1;
    end

    if (state_r == rmkq_pkg::S_IDLE && in_valid) begin
      x_r <= in_rssi_sample;
    end

    if (state_r == rmkq_pkg::S_MED) begin
      full_r <= med_full;
      meas_r <= med_meas;
      if (!started_r) begin
        q88_r <= {med_meas, 8'b0};
      end
    end

    // Variance walk over the history.
    if (state_nxt == rmkq_pkg::S_VSUM && state_r != rmkq_pkg::S_VSUM) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      sum_r    <= '0;
      sq_r     <= '0;
      post_r   <= (state_r == rmkq_pkg::S_HIST);
    end else if (state_r == rmkq_pkg::S_VSUM) begin
      if (walk_issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      rd_vld_r <= walk_issue;
      if (rd_vld_r) begin
        sum_r <= sum_r + SUM_W'(hist_q_r);
        sq_r  <= sq_r + SQ_W'(hsq[14:0]);
      end
    end

    if (state_r == rmkq_pkg::S_VMUL) begin
      na_r <= NUM_W'(hcnt_r) * NUM_W'(sq_r);
      nb_r <= sum_sqp[NUM_W-1:0];
      nn_r <= {{CNT_W{1'b0}}, hcnt_r} * {{CNT_W{1'b0}}, hcnt_r};
    end

    if (state_r == rmkq_pkg::S_PRED) begin
      pc_r   <= {1'b0, cov_r} + 33'(pnoise_r);
      diff_r <= {{10{meas_r[7]}}, meas_r, 16'b0} - {{2{est_r[31]}}, est_r};
    end

    if (state_r == rmkq_pkg::S_KDIV && div_done) begin
      k_r <= k_val;
    end

    // Serial shift-add multiplier: gain times innovation, then
    // one-minus-gain times predicted covariance.
    if (state_nxt == rmkq_pkg::S_KMUL && state_r != rmkq_pkg::S_KMUL) begin
      mc_r  <= 51'(diff_r);
      mp_r  <= k_val;
      acc_r <= '0;
    end else if (state_nxt == rmkq_pkg::S_PMUL && state_r != rmkq_pkg::S_PMUL) begin
      mc_r  <= 51'({1'b0, pc_r});
      mp_r  <= 17'h10000 - k_r;
      acc_r <= '0;
    end else if (state_r == rmkq_pkg::S_KMUL || state_r == rmkq_pkg::S_PMUL) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end

    if (state_r == rmkq_pkg::S_PUPD) begin
      q88_r <= q88_v;
    end

    if (state_r == rmkq_pkg::S_HIST && hcnt_inc < CNT_W'(3)) begin
      qual_r <= 16'h8000;
    end

    // Digit-by-digit square root of the variance scaled by 2^16.
    if (state_nxt == rmkq_pkg::S_SQRT && state_r != rmkq_pkg::S_SQRT) begin
      sv_r    <= {var_v, 16'b0};
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (state_r == rmkq_pkg::S_SQRT) begin
      sv_r    <= {sv_r[45:0], 2'b00};
      srem_r  <= sq_ge ? 26'(sq_trial - sq_t) : sq_trial[25:0];
      sroot_r <= {sroot_r[22:0], sq_ge};
    end

    if (state_r == rmkq_pkg::S_STAB && div_done) begin
      stab_r <= div_q[16:0];
    end
    if (state_r == rmkq_pkg::S_SRDIV && div_done) begin
      sr_r <= (div_q > DW'(65536)) ? 17'h10000 : div_q[16:0];
    end
    if (state_r == rmkq_pkg::S_QDIV && div_done) begin
      qual_r <= (div_q > DW'(65535)) ? 16'hFFFF : div_q[15:0];
    end

    if (state_r == rmkq_pkg::S_OUT && (!out_valid_r || out_ready)) begin
      out_rssi_r <= q88_r;
      out_qual_r <= qual_r;
      out_med_r  <= full_r;
    end
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_filtered_rssi  = out_rssi_r;
  assign out_signal_quality = out_qual_r;
  assign out_median_applied = out_med_r;

  // The gain never exceeds one.
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmkq_pkg::S_EUPD) |-> (k_r <= 17'h10000))
    else $error("Kalman gain above one");

  // The history count is bounded by the memory depth.
  a_hist_count: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  // A divider completion always belongs to an issued division.
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> issued_r)
    else $error("divider finished without a request");

  // The raw window count saturates at five.
  a_win_count: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= 3'(rmkq_pkg::WIN_LEN))
    else $error("window count beyond five");

endmodule

@@ hw/rtl/rmkq_div.sv @@
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only its top N bits are walked.
module rmkq_div #(
  parameter int DW = 49,
  parameter int VW = 34,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [CW-1:0] iters,
  output logic          done,
  output logic [DW-1:0] quotient
);

  logic [VW-1:0] rem_r;
  logic [DW-1:0] dv_r;
  logic [DW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_r, dv_r[DW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dv_r  <= dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? VW'(trial - {1'b0, divisor}) : VW'(trial);
      dv_r  <= {dv_r[DW-2:0], 1'b0};
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ tb/sv/tb_rssi_median_kalman_quality.sv @@
`timescale 1ns / 1ps

module tb_rssi_median_kalman_quality;

  // Quiet cycles added after each drain, so that any sample still in flight
  // has finished.
  localparam int SETTLE_CYCLES = 600;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_SAMPLES = 270;

  // Indexes past the last register; writes to them are ignored.
  localparam logic [rmkq_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd4;
  localparam logic [rmkq_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'd255;

  typedef struct {
    logic signed [15:0] rssi;
    logic [15:0]        quality;
    logic               median;
  } rssi_result_t;

  // The scoreboard holds its own copy of the filter state and predicts each
  // result when a sample beat is accepted. Results are checked in order.
  class kalman_scoreboard;
    logic [rmkq_pkg::CFG_W-1:0] proc_noise = rmkq_pkg::PROCESS_NOISE_RST;
    logic [rmkq_pkg::CFG_W-1:0] init_cov   = rmkq_pkg::INITIAL_COVARIANCE_RST;
    logic [rmkq_pkg::CFG_W-1:0] init_meas  = rmkq_pkg::INITIAL_MEAS_NOISE_RST;
    logic [rmkq_pkg::CFG_W-1:0] meas_floor = rmkq_pkg::NOISE_FLOOR_RST;
    int win [rmkq_pkg::WIN_LEN];
    int win_cnt = 0;
    int hist [16];
    int hist_cnt = 0;
    int hist_wr = 0;
    int est = 0;
    longint unsigned cov = 0;
    longint unsigned meas_noise = 0;
    bit started = 0;
    rssi_result_t pending_q [$];
    int errors = 0;
    int checked = 0;
    int samples = 0;

    function void write_reg(logic [rmkq_pkg::CFG_IDX_W-1:0] idx,
                            logic [rmkq_pkg::CFG_W-1:0] val);
      case (idx)
        rmkq_pkg::REG_PROCESS_NOISE:      proc_noise = val;
        rmkq_pkg::REG_INITIAL_COVARIANCE: init_cov = val;
        rmkq_pkg::REG_INITIAL_MEAS_NOISE: init_meas = val;
        rmkq_pkg::REG_NOISE_FLOOR:        meas_floor = val;
        default: ;
      endcase
    endfunction

    // Exact population variance of the history in Q16.16, truncated.
    function longint unsigned spread();
      longint s;
      longint sq;
      longint num;
      longint unsigned n;
      s = 0;
      sq = 0;
      for (int i = 0; i < hist_cnt; i++) begin
        s += hist[i];
        sq += hist[i] * hist[i];
      end
      if (hist_cnt == 0) return 0;
      n = hist_cnt;
      num = longint'(hist_cnt) * sq - s * s;
      return (unsigned'(num) << 16) / (n * n);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Right shift with rounding half away from zero.
    function longint round_shift(longint v, int s);
      longint unsigned mag;
      mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_sample(rmkq_pkg::sample_t smp);
      int x;
      int meas;
      int srt [rmkq_pkg::WIN_LEN];
      int t;
      bit full;
      longint unsigned pc, den, k, pn, v, root, stab, srs, qual;
      longint diff, sr, q;
      rssi_result_t r;
      x = smp;
      samples++;
      for (int i = 0; i < rmkq_pkg::WIN_LEN - 1; i++) win[i] = win[i + 1];
      win[rmkq_pkg::WIN_LEN - 1] = x;
      if (win_cnt < rmkq_pkg::WIN_LEN) win_cnt++;
      full = (win_cnt >= rmkq_pkg::WIN_LEN);
      meas = x;
      if (full) begin
        srt = win;
        for (int i = 0; i < rmkq_pkg::WIN_LEN; i++) begin
          for (int j = 0; j < rmkq_pkg::WIN_LEN - 1 - i; j++) begin
            if (srt[j] > srt[j + 1]) begin
              t = srt[j];
              srt[j] = srt[j + 1];
              srt[j + 1] = t;
            end
          end
        end
        meas = srt[2];
      end

      if (!started) begin
        // The first sample seeds the filter and passes through as is.
        est = x * 65536;
        cov = init_cov;
        meas_noise = init_meas;
        started = 1;
        r.rssi = 16'(meas * 256);
      end else begin
        if (hist_cnt > 5) begin
          v = spread();
          meas_noise = (v > meas_floor) ? v : meas_floor;
        end
        pc = cov + proc_noise;
        den = pc + meas_noise;
        // With no covariance and no noise the gain is zero and the estimate holds.
        k = (den == 0) ? 0 : (pc << 16) / den;
        diff = longint'(meas) * 65536 - longint'(est);
        est = int'(longint'(est) + round_shift(longint'(k) * diff, 16));
        pn = ((64'd65536 - k) * pc) >> 16;
        cov = (pn > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : pn;
        q = round_shift(longint'(est), 8);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.rssi = q[15:0];
      end

      hist[hist_wr] = x;
      hist_wr = (hist_wr + 1) % 16;
      if (hist_cnt < 16) hist_cnt++;

      if (hist_cnt < 3) begin
        qual = 32768;
      end else begin
        v = spread();
        root = int_sqrt(v << 16);
        stab = (64'd1 << 32) / (64'd65536 + root);
        sr = longint'(est) + 6553600;
        if (sr < 0) sr = 0;
        sr = sr / 100;
        if (sr > 65536) sr = 65536;
        srs = unsigned'(sr);
        qual = (6 * stab + 4 * srs + 5) / 10;
      end
      if (qual > 65535) qual = 65535;
      r.quality = qual[15:0];
      r.median = full;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(rssi_result_t got);
      rssi_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat rssi=%0d quality=%0d median=%0b",
                 $time, got.rssi, got.quality, got.median);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (got.rssi !== exp_r.rssi) begin
        $display("%0t: filtered_rssi expected %0d actual %0d", $time, exp_r.rssi, got.rssi);
        errors++;
      end
      if (got.quality !== exp_r.quality) begin
        $display("%0t: signal_quality expected %0d actual %0d", $time, exp_r.quality,
                 got.quality);
        errors++;
      end
      if (got.median !== exp_r.median) begin
        $display("%0t: median_applied expected %0b actual %0b", $time, exp_r.median,
                 got.median);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rmkq_pkg::sample_t in_rssi_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_filtered_rssi;
  logic [15:0] out_signal_quality;
  logic out_median_applied;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rmkq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rmkq_pkg::CFG_W-1:0] cfg_data = '0;

  // When set, neither side idles, so samples go through back to back.
  bit quiet = 0;
  kalman_scoreboard sb = new();

  rssi_median_kalman_quality #(.HISTORY_DEPTH(16)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rssi_sample     (in_rssi_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_rssi  (out_filtered_rssi),
    .out_signal_quality (out_signal_quality),
    .out_median_applied (out_median_applied),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #10 clk = ~clk;

  // The receiver stalls about one cycle in five unless the quiet stretch is on.
  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // Result beats are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    rssi_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.rssi = out_filtered_rssi;
      got.quality = out_signal_quality;
      got.median = out_median_applied;
      sb.check_result(got);
    end
  end

  // Sends one sample beat. Valid stays high between back-to-back beats and is
  // lowered only for an idle gap or when the stimulus pauses.
  task automatic send_sample(rmkq_pkg::sample_t smp);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rssi_sample <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(smp);
  endtask

  task automatic write_cfg(logic [rmkq_pkg::CFG_IDX_W-1:0] idx,
                           logic [rmkq_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding result arrive so that the block is idle again.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(logic [rmkq_pkg::CFG_W-1:0] pn, logic [rmkq_pkg::CFG_W-1:0] ic,
                           logic [rmkq_pkg::CFG_W-1:0] im, logic [rmkq_pkg::CFG_W-1:0] nf);
    write_cfg(rmkq_pkg::REG_PROCESS_NOISE, pn);
    write_cfg(rmkq_pkg::REG_INITIAL_COVARIANCE, ic);
    write_cfg(rmkq_pkg::REG_INITIAL_MEAS_NOISE, im);
    write_cfg(rmkq_pkg::REG_NOISE_FLOOR, nf);
  endtask

  function automatic logic [rmkq_pkg::CFG_W-1:0] rand_reg();
    return rmkq_pkg::CFG_W'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20));
  endfunction

  // A sample near the current level most of the time, with occasional spikes
  // for the median to reject and some full-range values to toggle every bit.
  function automatic rmkq_pkg::sample_t pick_sample(int level);
    int v;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) v = level + $urandom_range(0, 12) - 6;
    else if (sel < 80) v = level + $urandom_range(0, 80) - 40;
    else v = $urandom_range(0, 255) - 128;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return rmkq_pkg::sample_t'(v);
  endfunction

  initial begin
    rmkq_pkg::sample_t directed [$];
    int level;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero covariance and zero noise so the gain starts as zero and the
    // estimate holds; writes to unused indexes must be ignored.
    write_all('0, '0, '0, '0);
    write_cfg(REG_UNUSED_FIRST, 24'hABCDEF);
    write_cfg(REG_UNUSED_LAST, 24'hFF_FFFF);
    directed = '{0, 0, 0, 0, 0, 0, 0, 0, 127, -128, 127, -128, 1, -1,
                 85, -86, 127, 127, -128, -128, 0};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        1: write_all(rmkq_pkg::PROCESS_NOISE_RST, rmkq_pkg::INITIAL_COVARIANCE_RST,
                     rmkq_pkg::INITIAL_MEAS_NOISE_RST, rmkq_pkg::NOISE_FLOOR_RST);
        2: write_all('0, '0, '0, '0);
        default: write_all(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      endcase
      level = $urandom_range(0, 100) - 110;
      quiet = (p == 3);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if ($urandom_range(0, 99) < 3) level = $urandom_range(0, 100) - 110;
        send_sample(pick_sample(level));
      end
      drain();
      quiet = 0;
    end

    $display("Sent %0d RSSI samples and checked %0d result beats over %0d settings.",
             sb.samples, sb.checked, RANDOM_PHASES + 1);
    $display("Covered zero-gain hold, full-scale noise registers and a no-stall stretch.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** rssi_median_kalman_quality: PASSED **");
    end else begin
      $display("** rssi_median_kalman_quality: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending_q.size());
    $display("** rssi_median_kalman_quality: FAILED **");
    $finish;
  end

endmodule
